### hw/rtl/hrst_pkg.sv
package hrst_pkg;

  localparam int RingDepth = 64;
  localparam int NodeBits  = 8;
  localparam int IdxBits   = $clog2(RingDepth);
  localparam int CntBits   = $clog2(RingDepth + 1);
  localparam int QDepth    = 2;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [NodeBits-1:0] node_id;
    logic [31:0]         hash_value;
  } in_item_t;

  typedef struct packed {
    logic [NodeBits-1:0] owner_node;
    logic                found;
    logic [1:0]          status;
  } out_item_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    BS_IDLE,
    BS_SRCH_RD,
    BS_SRCH_CMP,
    BS_ADD_DECIDE,
    BS_SHIFT_RD,
    BS_SHIFT_WR,
    BS_ADD_WR,
    BS_RM_RD,
    BS_RM_WR,
    BS_LK_RD,
    BS_LK_DONE,
    BS_RESULT
  } bstate_t;

endpackage

### hw/rtl/hrst_front.sv
module hrst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  hrst_pkg::in_item_t in_data,
  output logic              q_valid,
  output hrst_pkg::in_item_t q_data,
  input  logic              q_take
);
  import hrst_pkg::*;

  in_item_t           mem_r [QDepth];
  logic               wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               push_ok, take_ok;
  in_item_t           clean;

  assign in_full = (cnt_r == 2'(QDepth));
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rp_r];
  assign push_ok = in_push && !in_full;
  assign take_ok = q_take && q_valid;

  // Classify: a REQ_NONE request has its node_id and hash_value cleared.
  always_comb begin
    clean = in_data;
    if (in_data.req_type == REQ_NONE) begin
      clean.node_id    = '0;
      clean.hash_value = '0;
    end
  end

  always_comb begin
    wp_nxt  = push_ok ? ~wp_r : wp_r;
    rp_nxt  = take_ok ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(take_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r] <= clean;
    end
  end

endmodule

### hw/rtl/hrst_back.sv
module hrst_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hrst_pkg::in_item_t q_data,
  output logic               q_take,
  output logic               out_empty,
  input  logic               out_pop,
  output hrst_pkg::out_item_t out_data
);
  import hrst_pkg::*;

  logic [31:0]         hmem [RingDepth];
  logic [NodeBits-1:0] omem [RingDepth];

  bstate_t              st_r, st_nxt;
  in_item_t             req_r, req_nxt;
  logic [CntBits-1:0]   count_r, count_nxt;
  logic [CntBits-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CntBits-1:0]   ptr_r, ptr_nxt, wr_r, wr_nxt;
  out_item_t            acc_r, acc_nxt;
  out_item_t            res_r, res_nxt;
  logic                 res_v_r, res_v_nxt;

  logic [IdxBits-1:0]   rd_addr;
  logic [31:0]          rd_h;
  logic [NodeBits-1:0]  rd_o;
  logic                 we;
  logic [IdxBits-1:0]   wr_addr;
  logic [31:0]          wr_h;
  logic [NodeBits-1:0]  wr_o;
  logic                 we_h;
  logic [CntBits-1:0]   mid;
  logic                 go_right;

  assign out_empty = !res_v_r;
  assign out_data  = res_r;
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  // Add searches lower bound, lookup searches upper bound.
  assign go_right  = (req_r.req_type == REQ_ADD) ? (rd_h < req_r.hash_value)
                                                 : (rd_h <= req_r.hash_value);

  // Memory ports: one registered read, one write.
  always_ff @(posedge clk) begin
    rd_h <= hmem[rd_addr];
    rd_o <= omem[rd_addr];
    if (we) begin
      omem[wr_addr] <= wr_o;
      if (we_h) begin
        hmem[wr_addr] <= wr_h;
      end
    end
  end

  always_comb begin
    st_nxt    = st_r;
    req_nxt   = req_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ptr_nxt   = ptr_r;
    wr_nxt    = wr_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    res_v_nxt = res_v_r;
    q_take    = 1'b0;
    rd_addr   = mid[IdxBits-1:0];
    we        = 1'b0;
    we_h      = 1'b1;
    wr_addr   = '0;
    wr_h      = req_r.hash_value;
    wr_o      = req_r.node_id;
    if (out_pop && res_v_r) begin
      res_v_nxt = 1'b0;
    end
    case (st_r)
      BS_IDLE: begin
        if (q_valid) begin
          q_take  = 1'b1;
          req_nxt = q_data;
          lo_nxt  = '0;
          hi_nxt  = count_r;
          ptr_nxt = '0;
          wr_nxt  = '0;
          acc_nxt = '0;
          case (req_type_t'(q_data.req_type))
            REQ_ADD:    st_nxt = BS_SRCH_RD;
            REQ_REMOVE: st_nxt = BS_RM_RD;
            REQ_LOOKUP: begin
              if (count_r == '0) begin
                acc_nxt.status = ST_EMPTY;
                st_nxt = BS_RESULT;
              end else begin
                st_nxt = BS_SRCH_RD;
              end
            end
            default:    st_nxt = BS_RESULT;
          endcase
        end
      end
      // Binary search: read mid, then compare.
      BS_SRCH_RD: begin
        if (lo_r < hi_r) begin
          st_nxt = BS_SRCH_CMP;
        end else if (req_r.req_type == REQ_ADD) begin
          rd_addr = lo_r[IdxBits-1:0];
          st_nxt  = BS_ADD_DECIDE;
        end else begin
          rd_addr = (lo_r >= count_r) ? '0 : lo_r[IdxBits-1:0];
          st_nxt  = BS_LK_DONE;
        end
      end
      BS_SRCH_CMP: begin
        if (go_right) lo_nxt = mid + 1'b1;
        else          hi_nxt = mid;
        st_nxt = BS_SRCH_RD;
      end
      BS_ADD_DECIDE: begin
        if (lo_r < count_r && rd_h == req_r.hash_value) begin
          we      = 1'b1;
          we_h    = 1'b0;
          wr_addr = lo_r[IdxBits-1:0];
          st_nxt  = BS_RESULT;
        end else if (count_r == CntBits'(RingDepth)) begin
          acc_nxt.status = ST_FULL;
          st_nxt = BS_RESULT;
        end else begin
          ptr_nxt = count_r;
          st_nxt  = BS_SHIFT_RD;
        end
      end
      // Shift entries up from the top down to the insert point.
      BS_SHIFT_RD: begin
        rd_addr = IdxBits'(ptr_r - 1'b1);
        st_nxt  = (ptr_r > lo_r) ? BS_SHIFT_WR : BS_ADD_WR;
      end
      BS_SHIFT_WR: begin
        we      = 1'b1;
        wr_addr = ptr_r[IdxBits-1:0];
        wr_h    = rd_h;
        wr_o    = rd_o;
        ptr_nxt = ptr_r - 1'b1;
        st_nxt  = BS_SHIFT_RD;
      end
      BS_ADD_WR: begin
        we        = 1'b1;
        wr_addr   = lo_r[IdxBits-1:0];
        count_nxt = count_r + 1'b1;
        st_nxt    = BS_RESULT;
      end
      // Compaction: read each entry, keep the ones of other nodes.
      BS_RM_RD: begin
        rd_addr = ptr_r[IdxBits-1:0];
        if (ptr_r < count_r) begin
          st_nxt = BS_RM_WR;
        end else begin
          count_nxt = wr_r;
          st_nxt    = BS_RESULT;
        end
      end
      BS_RM_WR: begin
        if (rd_o != req_r.node_id) begin
          we      = 1'b1;
          wr_addr = wr_r[IdxBits-1:0];
          wr_h    = rd_h;
          wr_o    = rd_o;
          wr_nxt  = wr_r + 1'b1;
        end
        ptr_nxt = ptr_r + 1'b1;
        st_nxt  = BS_RM_RD;
      end
      BS_LK_RD: st_nxt = BS_LK_DONE;
      BS_LK_DONE: begin
        acc_nxt.owner_node = rd_o;
        acc_nxt.found      = 1'b1;
        st_nxt = BS_RESULT;
      end
      // The result register is loaded only once the previous result has left.
      BS_RESULT: begin
        if (!res_v_r || out_pop) begin
          res_nxt   = acc_r;
          res_v_nxt = 1'b1;
          st_nxt    = BS_IDLE;
        end
      end
      default: st_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BS_IDLE;
      count_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    ptr_r <= ptr_nxt;
    wr_r  <= wr_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

endmodule

### hw/rtl/hash_ring_successor_table_unit.sv
// Channel | Direction | Handshake        | Payload
// in      | input     | in_push/in_full  | in_data (req_type, node_id, hash_value)
// out     | output    | out_pop/out_empty| out_data (owner_node, found, status)
//
// From leaving the queue, a lookup runs a binary search over the sorted table (a lookup
// on an empty ring is answered with ST_EMPTY), an add runs the search and then shifts
// each entry above the insert point up one by one, and a remove reads every stored point
// once to compact the table. Reset is synchronous and empties the ring.
// A two-entry request queue keeps accepting, until it is full, while the back end works or
// while a result waits to be popped.
module hash_ring_successor_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  hrst_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output hrst_pkg::out_item_t out_data
);
  import hrst_pkg::*;

  logic     q_valid, q_take;
  in_item_t q_data;

  hrst_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .q_valid, .q_data, .q_take
  );

  hrst_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_take,
    .out_empty, .out_pop, .out_data
  );

endmodule
